### hdl/wa2rgb_pkg.sv
// types and constants for the wheel angle to rgb colour pipeline
`default_nettype none

package wa2rgb_pkg;

  // swept component; the unused code falls back to hue sweep
  typedef enum logic [1:0] {
    MODE_HUE = 2'd0,
    MODE_SAT = 2'd1,
    MODE_VAL = 2'd2,
    MODE_ALT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_HUE  = 2'd1,
    REG_SAT  = 2'd2,
    REG_VAL  = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgDataW = 9;

  localparam logic [1:0] ModeReset = 2'd0;
  localparam logic [8:0] HueReset  = 9'd0;
  localparam logic [6:0] SatReset  = 7'd100;
  localparam logic [6:0] ValReset  = 7'd100;

  localparam logic [8:0]  DegWrap   = 9'd360;
  // percent * 51 / 20: multiply by 51, then /4 as a shift, /5 as 3277 >> 14
  localparam logic [12:0] PctMul    = 13'd51;
  localparam logic [22:0] DivFive   = 23'd3277;
  // degrees * 1536 / 360 = deg * 64 / 15, done as deg * 69906 >> 14
  localparam logic [25:0] DegToHue  = 26'd69906;
  localparam logic [7:0]  ByteMax   = 8'hff;

endpackage

`default_nettype wire

### hdl/wheel_angle_to_rgb.sv
// wheel position to approximate rgb colour, four stage pipeline
// the result strobes on done_o once the taken request has passed valid registers v1_q to v4_q
// throughput: one request per cycle; busy_o never rises, stages advance every cycle
// the four stages are the config scaling multiply, the reciprocal divide,
// the min and edge weight products, and the final slope product with channel routing
// reset clears all stage valid bits and loads the config registers with defaults
`default_nettype none

module wheel_angle_to_rgb (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [7:0]                         wheel_pos_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [wa2rgb_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic                                    done_o,
  output logic [7:0]                              red_out_o,
  output logic [7:0]                              green_out_o,
  output logic [7:0]                              blue_out_o
);

  // configuration registers
  logic [1:0] wheel_mode_q;
  logic [8:0] hue_setting_q;
  logic [6:0] sat_setting_q;
  logic [6:0] val_setting_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q  <= wa2rgb_pkg::ModeReset;
      hue_setting_q <= wa2rgb_pkg::HueReset;
      sat_setting_q <= wa2rgb_pkg::SatReset;
      val_setting_q <= wa2rgb_pkg::ValReset;
    end else if (cfg_we_i) begin
      unique case (wa2rgb_pkg::reg_idx_e'(cfg_idx_i))
        wa2rgb_pkg::REG_MODE: wheel_mode_q  <= cfg_data_i[1:0];
        wa2rgb_pkg::REG_HUE:  hue_setting_q <= cfg_data_i[8:0];
        wa2rgb_pkg::REG_SAT:  sat_setting_q <= cfg_data_i[6:0];
        wa2rgb_pkg::REG_VAL:  val_setting_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: capture request, wrap hue, scale percentages by 51
  logic [7:0]  pos1_q;
  logic [1:0]  mode1_q;
  logic [8:0]  hue1_d, hue1_q;
  logic [12:0] sat51_q, val51_q;

  always_comb begin
    hue1_d = hue_setting_q;
    if (hue_setting_q >= wa2rgb_pkg::DegWrap) begin
      hue1_d = hue_setting_q - wa2rgb_pkg::DegWrap;
    end
  end

  always_ff @(posedge clk_i) begin
    pos1_q  <= wheel_pos_i;
    mode1_q <= wheel_mode_q;
    hue1_q  <= hue1_d;
    sat51_q <= 13'(sat_setting_q) * wa2rgb_pkg::PctMul;
    val51_q <= 13'(val_setting_q) * wa2rgb_pkg::PctMul;
  end

  // stage 2: reciprocal divides, saturate, pick swept component
  logic [22:0] sat_prod, val_prod;
  logic [25:0] hue_prod;
  logic [8:0]  sat_full, val_full;
  logic [7:0]  sat_byte, val_byte;
  logic [10:0] hue_cfg;
  logic [10:0] hue2_d, hue2_q;
  logic [7:0]  sat2_d, sat2_q, val2_d, val2_q;

  always_comb begin
    sat_prod = 23'(sat51_q[12:2]) * wa2rgb_pkg::DivFive;
    val_prod = 23'(val51_q[12:2]) * wa2rgb_pkg::DivFive;
    hue_prod = 26'(hue1_q) * wa2rgb_pkg::DegToHue;
    sat_full = sat_prod[22:14];
    val_full = val_prod[22:14];
    sat_byte = sat_full[8] ? wa2rgb_pkg::ByteMax : sat_full[7:0];
    val_byte = val_full[8] ? wa2rgb_pkg::ByteMax : val_full[7:0];
    hue_cfg  = hue_prod[24:14];

    hue2_d = hue_cfg;
    sat2_d = sat_byte;
    val2_d = val_byte;
    unique case (wa2rgb_pkg::mode_e'(mode1_q))
      wa2rgb_pkg::MODE_SAT: sat2_d = pos1_q;
      wa2rgb_pkg::MODE_VAL: val2_d = pos1_q;
      default: hue2_d = (11'(pos1_q) << 2) + (11'(pos1_q) << 1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    hue2_q <= hue2_d;
    sat2_q <= sat2_d;
    val2_q <= val2_d;
  end

  // stage 3: sextant split, min channel and edge weight
  logic [2:0]  sext;
  logic [7:0]  frac;
  logic [16:0] w_prod;
  logic [15:0] lo_prod;
  logic [2:0]  sext3_q;
  logic [7:0]  lo3_q, wb3_q, val3_q;
  logic        grey3_q;

  always_comb begin
    sext = hue2_q[10:8];
    frac = hue2_q[7:0];
    if (!sext[0]) begin
      // rising edge; zero fraction gives the full saturation
      w_prod = 17'(sat2_q) * (17'd256 - 17'(frac));
    end else begin
      w_prod = 17'(sat2_q) * 17'(frac);
    end
    lo_prod = 16'(val2_q) * 16'(wa2rgb_pkg::ByteMax - sat2_q);
  end

  always_ff @(posedge clk_i) begin
    sext3_q <= sext;
    lo3_q   <= lo_prod[15:8];
    wb3_q   <= w_prod[15:8];
    val3_q  <= val2_q;
    grey3_q <= (sat2_q == 8'd0);
  end

  // stage 4: slope channel and routing by sextant
  logic [15:0] slope_prod;
  logic [7:0]  slope;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q;

  always_comb begin
    slope_prod = 16'(val3_q) * 16'(wa2rgb_pkg::ByteMax - wb3_q);
    slope      = slope_prod[15:8];
    if (grey3_q) begin
      red_d   = val3_q;
      green_d = val3_q;
      blue_d  = val3_q;
    end else begin
      case (sext3_q)
        3'd0: begin
          red_d = val3_q; green_d = slope;  blue_d = lo3_q;
        end
        3'd1: begin
          red_d = slope;  green_d = val3_q; blue_d = lo3_q;
        end
        3'd2: begin
          red_d = lo3_q;  green_d = val3_q; blue_d = slope;
        end
        3'd3: begin
          red_d = lo3_q;  green_d = slope;  blue_d = val3_q;
        end
        3'd4: begin
          red_d = slope;  green_d = lo3_q;  blue_d = val3_q;
        end
        default: begin
          red_d = val3_q; green_d = lo3_q;  blue_d = slope;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o      = v4_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

  // hue scale never leaves six sextants
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> hue2_q < 11'd1536)
    else $error("hue beyond six sextants");

  a_sext_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> sext3_q <= 3'd5)
    else $error("sextant out of range");

  // min channel can never exceed the value
  a_lo_le_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> lo3_q <= val3_q)
    else $error("min channel above value");

endmodule

`default_nettype wire

### dv/tb_top.sv
// self-checking testbench for the wheel position to rgb colour block
module tb_top;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned QuietPhases  = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  class colour_scoreboard;
    wa2rgb_pkg::mode_e mode;
    logic [8:0]  hue_deg;
    logic [6:0]  sat_pct;
    logic [6:0]  val_pct;
    rgb_t        colour_q[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned colours;

    function new();
      mode     = wa2rgb_pkg::mode_e'(wa2rgb_pkg::ModeReset);
      hue_deg  = wa2rgb_pkg::HueReset;
      sat_pct  = wa2rgb_pkg::SatReset;
      val_pct  = wa2rgb_pkg::ValReset;
      errors   = 0;
      requests = 0;
      colours  = 0;
    endfunction

    function void set_reg(wa2rgb_pkg::reg_idx_e idx, logic [wa2rgb_pkg::CfgDataW-1:0] data);
      case (idx)
        wa2rgb_pkg::REG_MODE: mode    = wa2rgb_pkg::mode_e'(data[1:0]);
        wa2rgb_pkg::REG_HUE:  hue_deg = data[8:0];
        wa2rgb_pkg::REG_SAT:  sat_pct = data[6:0];
        wa2rgb_pkg::REG_VAL:  val_pct = data[6:0];
        default: ;
      endcase
    endfunction

    // percent to 0..255 with clamp above 100
    function int unsigned pct_byte(logic [6:0] pct);
      int unsigned v;
      v = (int'(pct) * 51) / 20;
      return (v > 255) ? 255 : v;
    endfunction

    function rgb_t wheel_colour(logic [7:0] pos);
      int unsigned h, s, v, sext, frac, lo, w, slope;
      rgb_t c;
      case (mode)
        wa2rgb_pkg::MODE_SAT: begin
          h = ((int'(hue_deg) % 360) * 1536) / 360;
          s = pos;
          v = pct_byte(val_pct);
        end
        wa2rgb_pkg::MODE_VAL: begin
          h = ((int'(hue_deg) % 360) * 1536) / 360;
          s = pct_byte(sat_pct);
          v = pos;
        end
        default: begin
          h = int'(pos) * 6;
          s = pct_byte(sat_pct);
          v = pct_byte(val_pct);
        end
      endcase
      if (s == 0) begin
        c.red = v[7:0]; c.green = v[7:0]; c.blue = v[7:0];
        return c;
      end
      sext = (h >> 8) % 6;
      frac = h & 8'hff;
      lo = (v * (255 - s)) >> 8;
      // even sextants rise, odd ones fall
      w = (sext[0] == 1'b0) ? s * (256 - frac) : s * frac;
      slope = (v * (255 - ((w >> 8) & 8'hff))) >> 8;
      case (sext)
        0: begin c.red = v[7:0];     c.green = slope[7:0]; c.blue = lo[7:0];    end
        1: begin c.red = slope[7:0]; c.green = v[7:0];     c.blue = lo[7:0];    end
        2: begin c.red = lo[7:0];    c.green = v[7:0];     c.blue = slope[7:0]; end
        3: begin c.red = lo[7:0];    c.green = slope[7:0]; c.blue = v[7:0];     end
        4: begin c.red = slope[7:0]; c.green = lo[7:0];    c.blue = v[7:0];     end
        default: begin c.red = v[7:0]; c.green = lo[7:0]; c.blue = slope[7:0]; end
      endcase
      return c;
    endfunction

    function void note_request(logic [7:0] pos);
      colour_q.push_back(wheel_colour(pos));
      requests++;
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t exp_c;
      if (colour_q.size() == 0) begin
        $display("%0t: unexpected colour r=%0d g=%0d b=%0d", $time, r, g, b);
        errors++;
        return;
      end
      exp_c = colour_q.pop_front();
      colours++;
      if (r !== exp_c.red) begin
        $display("%0t: red expected %0d actual %0d", $time, exp_c.red, r);
        errors++;
      end
      if (g !== exp_c.green) begin
        $display("%0t: green expected %0d actual %0d", $time, exp_c.green, g);
        errors++;
      end
      if (b !== exp_c.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, b);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return colour_q.size();
    endfunction
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           start_i     = 1'b0;
  logic [7:0]                     wheel_pos_i = 8'd0;
  logic                           cfg_we_i    = 1'b0;
  logic [1:0]                     cfg_idx_i   = 2'd0;
  logic [wa2rgb_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           busy_o;
  logic                           done_o;
  logic [7:0]                     red_out_o;
  logic [7:0]                     green_out_o;
  logic [7:0]                     blue_out_o;

  colour_scoreboard sb = new();
  int unsigned      cycle_cnt  = 0;
  int unsigned      reg_writes = 0;

  wheel_angle_to_rgb uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .wheel_pos_i (wheel_pos_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(wheel_pos_i);
      if (done_o) sb.check_result(red_out_o, green_out_o, blue_out_o);
    end
  end

  task automatic send_request(input logic [7:0] pos, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start_i     <= 1'b0;
      wheel_pos_i <= 8'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    wheel_pos_i <= pos;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // hold off until every colour in flight has come back
  task automatic drain_colours();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // write enable is left high so writes can follow back to back
  task automatic write_reg(input wa2rgb_pkg::reg_idx_e idx,
                           input logic [wa2rgb_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic set_config(input wa2rgb_pkg::mode_e m, input logic [8:0] hue,
                            input logic [8:0] sat, input logic [8:0] val);
    drain_colours();
    write_reg(wa2rgb_pkg::REG_MODE, {7'($urandom), m});
    write_reg(wa2rgb_pkg::REG_HUE, hue);
    write_reg(wa2rgb_pkg::REG_SAT, sat);
    write_reg(wa2rgb_pkg::REG_VAL, val);
    cfg_we_i <= 1'b0;
  endtask

  // percent register values, weighted towards the edges and above 100
  function automatic logic [8:0] pick_pct();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd100;
      2: return 9'd127;
      3: return 9'($urandom);
      default: return 9'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    logic [8:0] hue;
    bit         may_idle;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: hue sweep across sextant boundaries
    send_request(8'd0, 1'b0);
    send_request(8'd42, 1'b0);
    send_request(8'd43, 1'b0);
    send_request(8'd128, 1'b0);
    send_request(8'd213, 1'b0);
    send_request(8'd255, 1'b0);
    // saturation sweep, hue at wrap point, value over range
    set_config(wa2rgb_pkg::MODE_SAT, 9'd360, 9'd100, 9'd127);
    send_request(8'd0, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd255, 1'b0);
    // value sweep with zero saturation, hue at the top code
    set_config(wa2rgb_pkg::MODE_VAL, 9'd511, 9'd0, 9'd100);
    send_request(8'd0, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd170, 1'b0);
    // spare mode code, over-range saturation, black
    set_config(wa2rgb_pkg::MODE_ALT, 9'd0, 9'd127, 9'd0);
    send_request(8'd85, 1'b0);
    send_request(8'd200, 1'b0);
    set_config(wa2rgb_pkg::MODE_HUE, 9'd0, 9'd0, 9'd100);
    send_request(8'd77, 1'b0);
    set_config(wa2rgb_pkg::MODE_VAL, 9'd359, 9'd100, 9'd100);
    send_request(8'd255, 1'b0);
    send_request(8'd128, 1'b0);

    for (int p = 0; p < RandPhases; p++) begin
      case ($urandom_range(0, 4))
        0: hue = 9'd0;
        1: hue = 9'd359;
        2: hue = 9'd360;
        3: hue = 9'd511;
        default: hue = 9'($urandom);
      endcase
      set_config(wa2rgb_pkg::mode_e'($urandom_range(0, 3)), hue, pick_pct(), pick_pct());
      may_idle = (p < RandPhases - QuietPhases) && (p % 3 != 1);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2 && $urandom_range(0, 1) == 0) drain_colours();
        send_request(8'($urandom), may_idle);
      end
    end

    drain_colours();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d colours never arrived", $time, sb.outstanding());
      sb.errors++;
    end
    $display("ran %0d requests and checked %0d colours across %0d register writes",
             sb.requests, sb.colours, reg_writes);
    $display("all sweep modes, hue wrap, zero and over-range saturation and value seen");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
